// File: hdl/bezs_pkg.sv
// Shared types and constants for the Bezier surface evaluator.
// No dependencies; imported by bezs_div, bezs_lerp, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bezs_pkg;

   // Build defaults
   localparam int MAX_DEGREE_DEF  = 3;
   localparam int COORD_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int DEG_W   = 2;
   localparam int STEP_W  = 11;
   localparam int IDX_IN_W = 2;
   localparam int OUT_W   = 32;
   localparam int T_W     = 17;                // Q1.16 parameter, 0..65536
   localparam int FRAC_W  = 16;
   localparam int NUM_W   = STEP_W + FRAC_W;   // divider numerator
   localparam int NUM_COORD = 3;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [STEP_W-1:0] MAX_STEPS = 11'd1024;

   // Input operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Register indexes (word address)
   localparam logic [1:0] REG_U_DEGREE   = 2'd0;
   localparam logic [1:0] REG_V_DEGREE   = 2'd1;
   localparam logic [1:0] REG_GRID_STEPS = 2'd2;

   localparam logic [1:0] COORD_LAST = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_U,
      ST_DIV_V,
      ST_RD,
      ST_RD_WAIT,
      ST_MUL,
      ST_ADD,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// File: hdl/bezs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bezs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// File: hdl/bezs_div.sv
// Restoring divider, one quotient bit per cycle, for the Q1.16 parameter.
// Depends on bezs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bezs_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bezs_pkg::NUM_W-1:0]  num,
   input  wire logic [bezs_pkg::STEP_W-1:0] den,
   output logic      [bezs_pkg::T_W-1:0]    quo,
   output logic                             done
);
   import bezs_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [STEP_W:0]  rem_ff, rem_in;
   logic [STEP_W:0]  rem_sh;
   logic             fits;

   // One restoring step
   always_comb begin
      rem_sh = {rem_ff[STEP_W-1:0], num_ff[NUM_W-1]};
      fits   = rem_sh >= {1'b0, den};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? (rem_sh - {1'b0, den}) : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quo  = quo_ff[T_W-1:0];
   assign done = done_ff;

endmodule

`default_nettype wire

// File: hdl/bezs_lerp.sv
// Shared fixed-point lerp: a registered multiply stage, then round and add.
// Depends on bezs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bezs_lerp #(
   parameter int COORD_WIDTH = bezs_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [COORD_WIDTH-1:0] a,
   input  wire logic signed [COORD_WIDTH-1:0] b,
   input  wire logic [bezs_pkg::T_W-1:0]      t,
   output logic signed [COORD_WIDTH-1:0]      res
);
   import bezs_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + 1 + FRAC_W;

   logic signed [CW:0]   diff;
   logic [CW:0]          mag;
   logic [PW-1:0]        prod;

   logic [PW-1:0]        prod_ff;
   logic                 neg_ff;
   logic                 one_ff;
   logic signed [CW-1:0] a_ff;
   logic signed [CW-1:0] b_ff;

   logic [PW-1:0]        rnd;
   logic signed [CW+1:0] step;
   logic signed [CW+1:0] sum;

   // Stage 1: magnitude of the difference times t
   always_comb begin
      diff = (CW+1)'(b) - (CW+1)'(a);
      mag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
      prod = PW'(mag) * PW'(t[FRAC_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod;
         neg_ff  <= diff[CW];
         one_ff  <= t[T_W-1];
         a_ff    <= a;
         b_ff    <= b;
      end
   end

   // Stage 2: round half away from zero and apply the step
   always_comb begin
      rnd  = prod_ff + PW'(1 << (FRAC_W - 1));
      step = (CW+2)'(rnd[PW-1:FRAC_W]);
      sum  = neg_ff ? ((CW+2)'(a_ff) - step) : ((CW+2)'(a_ff) + step);
      res  = one_ff ? b_ff : sum[CW-1:0];
   end

endmodule

`default_nettype wire

// File: hdl/bezier_surface_evaluator_top.sv
// Top level of the Bezier surface evaluator: APB registers, sequencer, grid RAM.
// Depends on bezs_pkg, bezs_ram, bezs_div, bezs_lerp.
//
// Usage:
//   Input channel: an item transfers at a rising edge with start high and busy
//   low. req_op = load writes one control point (req_row, req_col, req_in_*)
//   into the grid RAM in that cycle; no result, busy stays low.
//   req_op = evaluate computes the surface point at (req_grid_u, req_grid_v);
//   busy is high until the result has been presented.
//   Result channel: rsp_valid pulses for one cycle with rsp_out_x/y/z. The
//   receiver cannot stall; the result must be taken in that cycle.
//   An evaluate runs the two parameter divisions (one quotient bit per cycle),
//   then per coordinate reads each row of control points and reduces it along
//   v, then reduces the row points along u, all lerps on the single shared
//   multiplier; then the result is presented.
//   Registers (APB, word address): 0 u_degree, 1 v_degree, 2 grid_steps;
//   write only while idle. Reset restores degrees 3/3 and grid_steps 16;
//   the control grid is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module bezier_surface_evaluator_top #(
   parameter int MAX_DEGREE  = bezs_pkg::MAX_DEGREE_DEF,
   parameter int COORD_WIDTH = bezs_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [bezs_pkg::IDX_IN_W-1:0] req_row,
   input  wire logic [bezs_pkg::IDX_IN_W-1:0] req_col,
   input  wire logic signed [31:0]            req_in_x,
   input  wire logic signed [31:0]            req_in_y,
   input  wire logic signed [31:0]            req_in_z,
   input  wire logic [bezs_pkg::STEP_W-1:0]   req_grid_u,
   input  wire logic [bezs_pkg::STEP_W-1:0]   req_grid_v,
   // result channel
   output logic                               rsp_valid,
   output logic signed [31:0]                 rsp_out_x,
   output logic signed [31:0]                 rsp_out_y,
   output logic signed [31:0]                 rsp_out_z,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bezs_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [bezs_pkg::DATA_W-1:0]   pwdata,
   output logic      [bezs_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);
   import bezs_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int SIDE  = MAX_DEGREE + 1;
   localparam int IDX_W = $clog2(SIDE);
   localparam int RA_W  = 2 * IDX_W;
   localparam int DEPTH = 1 << RA_W;
   localparam int RW    = NUM_COORD * CW;

   // ---------------- registers ----------------
   logic [DEG_W-1:0]  u_degree_ff, v_degree_ff;
   logic [STEP_W-1:0] grid_steps_ff;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         u_degree_ff   <= 2'd3;
         v_degree_ff   <= 2'd3;
         grid_steps_ff <= 11'd16;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_U_DEGREE:   u_degree_ff   <= pwdata[DEG_W-1:0];
            REG_V_DEGREE:   v_degree_ff   <= pwdata[DEG_W-1:0];
            REG_GRID_STEPS: grid_steps_ff <= pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read back
   always_comb begin
      case (paddr[3:2])
         REG_U_DEGREE:   prdata = DATA_W'(u_degree_ff);
         REG_V_DEGREE:   prdata = DATA_W'(v_degree_ff);
         REG_GRID_STEPS: prdata = DATA_W'(grid_steps_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- helpers ----------------
   function automatic logic [IDX_W-1:0] clamp_deg(input logic [DEG_W-1:0] d);
      logic [IDX_W-1:0] r;
      if (d == '0) r = IDX_W'(1);
      else if (32'(d) > 32'(MAX_DEGREE)) r = IDX_W'(MAX_DEGREE);
      else r = IDX_W'(d);
      return r;
   endfunction

   function automatic logic signed [CW-1:0] sat_load(input logic signed [31:0] x);
      logic signed [63:0] v, hi, lo;
      logic signed [CW-1:0] r;
      v  = 64'(x);
      hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) r = hi[CW-1:0];
      else if (v < lo) r = lo[CW-1:0];
      else r = v[CW-1:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat_out(input logic signed [CW-1:0] x);
      logic signed [63:0] v;
      logic signed [31:0] r;
      v = 64'(x);
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // ---------------- command decode ----------------
   state_type state_ff, state_in;
   logic      accept, is_eval, load_ok;
   logic [STEP_W-1:0] steps_eff, gu_sat, gv_sat;
   logic [NUM_W-1:0]  num_u, num_v;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign is_eval = (req_op == OP_EVAL);
   assign load_ok = (32'(req_row) <= 32'(MAX_DEGREE)) && (32'(req_col) <= 32'(MAX_DEGREE));

   // Effective step count and saturated indices
   always_comb begin
      if (grid_steps_ff == '0) steps_eff = STEP_W'(1);
      else if (grid_steps_ff > MAX_STEPS) steps_eff = MAX_STEPS;
      else steps_eff = grid_steps_ff;
      gu_sat = (req_grid_u > steps_eff) ? steps_eff : req_grid_u;
      gv_sat = (req_grid_v > steps_eff) ? steps_eff : req_grid_v;
      num_u  = {gu_sat, FRAC_W'(0)} + NUM_W'(steps_eff >> 1);
      num_v  = {gv_sat, FRAC_W'(0)} + NUM_W'(steps_eff >> 1);
   end

   // ---------------- grid RAM ----------------
   logic [RA_W-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0]   ram_wdata, ram_rdata;
   logic            ram_we;

   assign ram_we    = accept && !is_eval && load_ok;
   assign ram_waddr = {IDX_W'(req_row), IDX_W'(req_col)};
   assign ram_wdata = {sat_load(req_in_z), sat_load(req_in_y), sat_load(req_in_x)};

   bezs_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- parameter divider ----------------
   logic [NUM_W-1:0]  num_v_ff, num_v_in;
   logic [STEP_W-1:0] den_ff, den_in;
   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_num;
   logic [STEP_W-1:0] div_den;
   logic [T_W-1:0]    div_quo;

   assign div_start = (accept && is_eval) || (state_ff == ST_DIV_U && div_done);
   assign div_num   = (state_ff == ST_IDLE) ? num_u : num_v_ff;
   assign div_den   = (state_ff == ST_IDLE) ? steps_eff : den_ff;

   bezs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   // ---------------- lerp unit ----------------
   logic signed [CW-1:0] q_ff [SIDE];
   logic signed [CW-1:0] q_in [SIDE];
   logic signed [CW-1:0] rp_ff [SIDE];
   logic signed [CW-1:0] rp_in [SIDE];
   logic [T_W-1:0]       tu_ff, tu_in, tv_ff, tv_in;
   logic                 phase_v_ff, phase_v_in;
   logic                 lerp_en;
   logic signed [CW-1:0] lerp_res;

   assign lerp_en = (state_ff == ST_MUL);

   bezs_lerp #(
      .COORD_WIDTH (CW)
   ) u_lerp (
      .clock (clock),
      .en    (lerp_en),
      .a     (q_ff[0]),
      .b     (q_ff[1]),
      .t     (phase_v_ff ? tv_ff : tu_ff),
      .res   (lerp_res)
   );

   // ---------------- sequencer counters ----------------
   logic [IDX_W-1:0] ud_ff, ud_in, vd_ff, vd_in;
   logic [IDX_W-1:0] i_ff, i_in, k_ff, k_in, r_ff, r_in, j_ff, j_in;
   logic [1:0]       c_ff, c_in;
   logic signed [31:0] res_ff [NUM_COORD];
   logic signed [31:0] res_in [NUM_COORD];
   logic [IDX_W-1:0] deg, lvl_top;
   logic             lvl_last, phase_last, row_last, coord_last, load_last;

   assign deg        = phase_v_ff ? vd_ff : ud_ff;
   assign lvl_top    = IDX_W'(deg - r_ff);
   assign lvl_last   = (j_ff == lvl_top);
   assign phase_last = (r_ff == deg);
   assign row_last   = (i_ff == ud_ff);
   assign coord_last = (c_ff == COORD_LAST);
   assign load_last  = (k_ff == vd_ff);
   assign ram_raddr  = {i_ff, k_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && is_eval) state_in = ST_DIV_U;
         ST_DIV_U:   if (div_done) state_in = ST_DIV_V;
         ST_DIV_V:   if (div_done) state_in = ST_RD;
         ST_RD:      state_in = ST_RD_WAIT;
         ST_RD_WAIT: state_in = load_last ? ST_MUL : ST_RD;
         ST_MUL:     state_in = ST_ADD;
         ST_ADD: begin
            if (lvl_last && phase_last) begin
               if (phase_v_ff) state_in = row_last ? ST_MUL : ST_RD;
               else state_in = coord_last ? ST_OUT : ST_RD;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_OUT:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and counter updates
   always_comb begin
      tu_in      = tu_ff;
      tv_in      = tv_ff;
      num_v_in   = num_v_ff;
      den_in     = den_ff;
      ud_in      = ud_ff;
      vd_in      = vd_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      r_in       = r_ff;
      j_in       = j_ff;
      c_in       = c_ff;
      phase_v_in = phase_v_ff;
      q_in       = q_ff;
      rp_in      = rp_ff;
      res_in     = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_eval) begin
               num_v_in = num_v;
               den_in   = steps_eff;
               ud_in    = clamp_deg(u_degree_ff);
               vd_in    = clamp_deg(v_degree_ff);
            end
         end
         ST_DIV_U: begin
            if (div_done) tu_in = div_quo;
         end
         ST_DIV_V: begin
            if (div_done) begin
               tv_in      = div_quo;
               c_in       = '0;
               i_in       = '0;
               k_in       = '0;
               phase_v_in = 1'b1;
            end
         end
         ST_RD_WAIT: begin
            q_in[k_ff] = ram_rdata[c_ff*CW +: CW];
            if (load_last) begin
               r_in = IDX_W'(1);
               j_in = '0;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_ADD: begin
            // Queue shifts past consumed points; new point goes to the level tail
            if (lvl_last) begin
               for (int n = 0; n < SIDE - 2; n++) q_in[n] = q_ff[n+2];
               q_in[lvl_top] = lerp_res;
               r_in = r_ff + 1'b1;
               j_in = '0;
            end else begin
               for (int n = 0; n < SIDE - 1; n++) q_in[n] = q_ff[n+1];
               q_in[IDX_W'(lvl_top + 1'b1)] = lerp_res;
               j_in = j_ff + 1'b1;
            end
            if (lvl_last && phase_last) begin
               if (phase_v_ff) begin
                  rp_in[i_ff] = lerp_res;
                  if (row_last) begin
                     // Row points become the column to reduce along u
                     for (int n = 0; n < SIDE; n++) q_in[n] = rp_ff[n];
                     q_in[i_ff] = lerp_res;
                     phase_v_in = 1'b0;
                     r_in       = IDX_W'(1);
                     j_in       = '0;
                  end else begin
                     i_in = i_ff + 1'b1;
                     k_in = '0;
                  end
               end else begin
                  res_in[c_ff] = sat_out(lerp_res);
                  c_in       = c_ff + 1'b1;
                  i_in       = '0;
                  k_in       = '0;
                  phase_v_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      tu_ff      <= tu_in;
      tv_ff      <= tv_in;
      num_v_ff   <= num_v_in;
      den_ff     <= den_in;
      ud_ff      <= ud_in;
      vd_ff      <= vd_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      r_ff       <= r_in;
      j_ff       <= j_in;
      c_ff       <= c_in;
      phase_v_ff <= phase_v_in;
      q_ff       <= q_in;
      rp_ff      <= rp_in;
      res_ff     <= res_in;
   end

   // Result strobe
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_out_x = res_ff[0];
   assign rsp_out_y = res_ff[1];
   assign rsp_out_z = res_ff[2];

endmodule

`default_nettype wire

// File: tb/sv/bezier_surface_evaluator_top_tb.sv
// Self-checking testbench for the Bezier surface evaluator top level.
// Depends on bezs_pkg and the RTL under hdl/; predicts every evaluation in a scoreboard class.
`timescale 1ns / 1ps

module bezier_surface_evaluator_top_tb;
   import bezs_pkg::*;

   typedef struct {
      logic               op;
      logic [1:0]         row;
      logic [1:0]         col;
      logic signed [31:0] x, y, z;
      logic [STEP_W-1:0]  gu, gv;
   } command_type;

   typedef struct {
      logic signed [31:0] x, y, z;
   } point_type;

   // Surface predictor plus queue of expected points
   class surface_scoreboard;
      longint  grid[4][4][3];
      bit [1:0] u_deg, v_deg;
      bit [STEP_W-1:0] steps;
      point_type expected_points[$];
      int      mismatches;
      int      evals, loads, points_seen;

      function new();
         u_deg = 3;
         v_deg = 3;
         steps = 16;
         foreach (grid[i, j, c]) grid[i][j][c] = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_U_DEGREE:   u_deg = val[1:0];
            REG_V_DEGREE:   v_deg = val[1:0];
            REG_GRID_STEPS: steps = val[STEP_W-1:0];
            default: ;
         endcase
      endfunction

      // a + rounded fraction of (b - a), magnitude rounded half away from zero
      function longint blend(longint a, longint b, bit [16:0] t);
         longint d;
         longint unsigned m, p;
         if (t >= 17'd65536) return b;
         d = b - a;
         m = (d < 0) ? -d : d;
         p = (m * t + 64'd32768) >> 16;
         return (d < 0) ? a - longint'(p) : a + longint'(p);
      endfunction

      function bit [16:0] param(bit [STEP_W-1:0] g, int s);
         longint unsigned gg;
         gg = (g > s) ? s : g;
         return 17'((gg * 65536 + s / 2) / s);
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void note_command(command_type cmd);
         int ud, vd, s;
         bit [16:0] tu, tv;
         longint rowpts[4][3];
         longint work[4][3];
         point_type pt;
         if (cmd.op == OP_LOAD) begin
            grid[cmd.row][cmd.col][0] = cmd.x;
            grid[cmd.row][cmd.col][1] = cmd.y;
            grid[cmd.row][cmd.col][2] = cmd.z;
            loads++;
            return;
         end
         ud = (u_deg == 0) ? 1 : u_deg;
         vd = (v_deg == 0) ? 1 : v_deg;
         s = (steps == 0) ? 1 : ((steps > MAX_STEPS) ? MAX_STEPS : steps);
         tu = param(cmd.gu, s);
         tv = param(cmd.gv, s);
         // reduce each row along v, then the column of row points along u
         for (int i = 0; i <= ud; i++) begin
            for (int k = 0; k <= vd; k++)
               for (int c = 0; c < 3; c++) work[k][c] = grid[i][k][c];
            for (int r = 1; r <= vd; r++)
               for (int k = 0; k + r <= vd; k++)
                  for (int c = 0; c < 3; c++)
                     work[k][c] = blend(work[k][c], work[k+1][c], tv);
            for (int c = 0; c < 3; c++) rowpts[i][c] = work[0][c];
         end
         for (int r = 1; r <= ud; r++)
            for (int k = 0; k + r <= ud; k++)
               for (int c = 0; c < 3; c++)
                  rowpts[k][c] = blend(rowpts[k][c], rowpts[k+1][c], tu);
         pt.x = sat32(rowpts[0][0]);
         pt.y = sat32(rowpts[0][1]);
         pt.z = sat32(rowpts[0][2]);
         expected_points.push_back(pt);
         evals++;
      endfunction

      function void compare_point(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z);
         point_type e;
         points_seen++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected point %0d %0d %0d at %0t", x, y, z, $realtime);
            return;
         end
         e = expected_points.pop_front();
         if (x !== e.x || y !== e.y || z !== e.z) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: point #%0d exp (%0d %0d %0d) got (%0d %0d %0d) at %0t",
                        points_seen, e.x, e.y, e.z, x, y, z, $realtime);
         end
      endfunction
   endclass

   logic clock, reset;
   logic start, busy;
   logic req_op;
   logic [1:0] req_row, req_col;
   logic signed [31:0] req_in_x, req_in_y, req_in_z;
   logic [STEP_W-1:0] req_grid_u, req_grid_v;
   logic rsp_valid;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;
   logic pready;

   surface_scoreboard sb;
   int item_count;
   int cfg_writes;
   bit no_idle;

   bezier_surface_evaluator_top u_dut (
      .clock, .reset, .start, .busy,
      .req_op, .req_row, .req_col, .req_in_x, .req_in_y, .req_in_z,
      .req_grid_u, .req_grid_v,
      .rsp_valid, .rsp_out_x, .rsp_out_y, .rsp_out_z,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result monitor: every strobed point is checked at the edge ending its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.compare_point(rsp_out_x, rsp_out_y, rsp_out_z);
   end

   // one command transfer, with an optional random gap before it
   task automatic send_command(command_type cmd);
      if (!no_idle && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start      <= 1'b1;
      req_op     <= cmd.op;
      req_row    <= cmd.row;
      req_col    <= cmd.col;
      req_in_x   <= cmd.x;
      req_in_y   <= cmd.y;
      req_in_z   <= cmd.z;
      req_grid_u <= cmd.gu;
      req_grid_v <= cmd.gv;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(cmd);
      item_count++;
   endtask

   task automatic load_point(int r, int c, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      command_type cmd;
      cmd = '{op: OP_LOAD, row: r, col: c, x: x, y: y, z: z, gu: $urandom, gv: $urandom};
      send_command(cmd);
   endtask

   task automatic eval_at(int gu, int gv);
      command_type cmd;
      cmd = '{op: OP_EVAL, row: $urandom, col: $urandom, x: $urandom, y: $urandom,
              z: $urandom, gu: gu, gv: gv};
      send_command(cmd);
   endtask

   // wait until every expected point has arrived, then let the block settle
   task automatic drain();
      start <= 1'b0;
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, val);
      cfg_writes++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
      endcase
   endfunction

   task automatic random_phase(int n);
      int s;
      s = (sb.steps == 0) ? 1 : ((sb.steps > MAX_STEPS) ? MAX_STEPS : sb.steps);
      for (int i = 0; i < n; i++) begin
         no_idle = (item_count >= 500 && item_count < 800);
         if ($urandom_range(0, 99) < 45)
            load_point($urandom_range(0, 3), $urandom_range(0, 3),
                       rand_coord(), rand_coord(), rand_coord());
         else if ($urandom_range(0, 9) == 0)
            eval_at($urandom_range(0, 2047), $urandom_range(0, 2047));
         else
            eval_at($urandom_range(0, s), $urandom_range(0, s));
         if (i == n / 2) drain();   // sender holds off until all points are back
      end
      drain();
   endtask

   initial begin
      int u_list[6] = '{3, 0, 1, 2, 3, 1};
      int v_list[6] = '{3, 0, 2, 1, 1, 3};
      int s_list[6] = '{16, 0, 1024, 2047, 1, 7};
      sb = new();
      item_count = 0;
      cfg_writes = 0;
      no_idle = 0;
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_LOAD;
      req_row = '0;
      req_col = '0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      req_grid_u = '0;
      req_grid_v = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full grid at coordinate extremes in a checker pattern
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            if ((r + c) % 2 == 0) load_point(r, c, 32'h7FFF_FFFF, 32'h8000_0000, 0);
            else load_point(r, c, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      eval_at(0, 0);
      eval_at(16, 16);
      eval_at(8, 8);
      eval_at(2047, 3);
      eval_at(1024, 0);
      eval_at(17, 5);
      drain();
      write_reg(REG_GRID_STEPS, 0);
      eval_at(1, 0);
      eval_at(0, 2047);
      drain();

      // random phases over several register settings
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_U_DEGREE, u_list[p]);
         write_reg(REG_V_DEGREE, v_list[p]);
         write_reg(REG_GRID_STEPS, s_list[p]);
         random_phase(220);
      end

      drain();
      repeat (400) @(posedge clock);
      $display("Covered %0d loads and %0d evaluations over %0d register writes;",
               sb.loads, sb.evals, cfg_writes);
      $display("degrees 0..3 and grid steps 0 to 2047, %0d mismatches.", sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_points.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("ERROR: timeout");
      $display("CHECK FAILED");
      $finish;
   end

endmodule
